/* hdl/ter_pkg.sv */
// Shared constants, register codes and control structs for the time-expansion resampler.
package ter_pkg;

    // Default history window depth
    localparam int WINDOW_DEFAULT = 64;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int IN_RATE_W  = 20;
    localparam int OUT_RATE_W = 20;
    localparam int EXP_W      = 7;
    localparam int STEP_W     = 22;
    localparam int CFG_W      = 22;
    localparam int CFG_ADDR_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_RATE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_RATE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPANSION   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP        = 2'd3;

    // Register reset values
    localparam logic [IN_RATE_W-1:0]  IN_RATE_RESET  = 20'd1;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_RESET = 20'd48000;
    localparam logic [EXP_W-1:0]      EXP_RESET      = 7'd8;
    localparam logic [STEP_W-1:0]     STEP_RESET     = 22'd65536;

    // Substitutes for a zero register
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_FALLBACK = 20'd48000;

    // Read position: Q16 fraction plus whole samples reached by 64 maximal steps
    localparam int FRAC_W = 16;
    localparam int POS_W  = 29;

    // Output count per item
    localparam int CNT_W   = 7;
    localparam int MAX_OUT = 64;

    // Divider: 28-bit dividend, two quotient bits per cycle
    localparam int NUM_W      = 28;
    localparam int REM_W      = 20;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STEPS  = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = 4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mult;
        logic div_step;
        logic count;
        logic calc;
        logic load;
        logic commit;
    } ter_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;
        logic none_due;
        logic last_out;
        logic out_free;
    } ter_sts_t;

endpackage

/* hdl/ter_ram.sv */
// Generic RAM with one write port and two registered read ports.
module ter_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read two with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hdl/ter_ctrl.sv */
// Controller state machine that sequences divide, interpolation and window update.
module ter_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output ter_pkg::ter_cmd_t cmd,
    input  ter_pkg::ter_sts_t sts
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL    = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_COUNT  = 8'b0000_1000,
        S_READ   = 8'b0001_0000,
        S_CALC   = 8'b0010_0000,
        S_LOAD   = 8'b0100_0000,
        S_COMMIT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Hold state, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through the per-item sequence
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mult   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                cmd.count  = 1'b1;
                state_next = sts.none_due ? S_COMMIT : S_READ;
            end
            S_READ: begin
                state_next = S_CALC;
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = sts.last_out ? S_COMMIT : S_READ;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

/* hdl/ter_dp.sv */
// Datapath: configuration registers, rate divider, history window and interpolator.
module ter_dp #(
    parameter int WINDOW = ter_pkg::WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ter_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ter_pkg::CFG_W-1:0]       cfg_data,
    input  logic [ter_pkg::SAMPLE_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ter_pkg::SAMPLE_W-1:0]    m_tdata,
    output logic                            m_tlast,
    input  ter_pkg::ter_cmd_t               cmd,
    output ter_pkg::ter_sts_t               sts
);

    localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW     = AW + 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int CONS_W = ter_pkg::POS_W - ter_pkg::FRAC_W;
    localparam int IDX_W  = CONS_W + 1;
    localparam int SMP_W  = ter_pkg::SAMPLE_W;
    localparam int PROD_W = 2 * (SMP_W + 1);
    localparam int Y_W    = PROD_W - ter_pkg::FRAC_W;
    localparam int EXF_W  = ter_pkg::EXP_W + ter_pkg::OUT_RATE_W;

    // Configuration registers
    logic [ter_pkg::IN_RATE_W-1:0]  in_rate_reg;
    logic [ter_pkg::OUT_RATE_W-1:0] out_rate_reg;
    logic [ter_pkg::EXP_W-1:0]      exp_reg;
    logic [ter_pkg::STEP_W-1:0]     step_reg;

    // Item state
    logic [ter_pkg::REM_W-1:0]      rem_reg;
    logic [ter_pkg::POS_W-1:0]      pos_reg;
    logic [AW-1:0]                  base_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic [SMP_W-1:0]               smp_reg;

    // Divider
    logic [ter_pkg::NUM_W-1:0]      num_reg, num_next;
    logic [ter_pkg::REM_W-1:0]      div_rem_reg, div_rem_next;
    logic [ter_pkg::DIV_CNT_W-1:0]  div_cnt_reg;

    // Output sequencing
    logic [ter_pkg::CNT_W-1:0]      n_reg;
    logic [ter_pkg::CNT_W-1:0]      out_cnt_reg;

    // Interpolator
    logic signed [PROD_W-1:0]       prod_reg;
    logic [SMP_W-1:0]               x0_reg;

    // Output register
    logic                           out_valid_reg;
    logic [SMP_W-1:0]               out_sample_reg;
    logic                           out_last_reg;

    // Effective settings with zero substitutes
    logic [ter_pkg::IN_RATE_W-1:0]  fin;
    logic [ter_pkg::OUT_RATE_W-1:0] fout;
    logic [ter_pkg::EXP_W-1:0]      ex;
    logic [ter_pkg::STEP_W-1:0]     step;
    logic [EXF_W-1:0]               exf;

    assign fin  = (in_rate_reg  == '0) ? ter_pkg::IN_RATE_W'(1) : in_rate_reg;
    assign fout = (out_rate_reg == '0) ? ter_pkg::OUT_RATE_FALLBACK : out_rate_reg;
    assign ex   = (exp_reg      == '0) ? ter_pkg::EXP_W'(1) : exp_reg;
    assign step = (step_reg     == '0) ? ter_pkg::STEP_W'(1) : step_reg;
    assign exf  = EXF_W'(ex) * EXF_W'(fout);

    // Map a window offset to a ring slot
    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] b,
                                                 input logic [SW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(b) + k;
        if (s >= SW'(WINDOW)) begin
            s = s - SW'(WINDOW);
        end
        return s[AW-1:0];
    endfunction

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= ter_pkg::IN_RATE_RESET;
            out_rate_reg <= ter_pkg::OUT_RATE_RESET;
            exp_reg      <= ter_pkg::EXP_RESET;
            step_reg     <= ter_pkg::STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ter_pkg::CFG_INPUT_RATE:  in_rate_reg  <= cfg_data[ter_pkg::IN_RATE_W-1:0];
                ter_pkg::CFG_OUTPUT_RATE: out_rate_reg <= cfg_data[ter_pkg::OUT_RATE_W-1:0];
                ter_pkg::CFG_EXPANSION:   exp_reg      <= cfg_data[ter_pkg::EXP_W-1:0];
                ter_pkg::CFG_STEP:        step_reg     <= cfg_data[ter_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Restoring divide, two quotient bits per cycle
    always_comb begin
        logic [ter_pkg::REM_W:0]   r;
        logic [ter_pkg::NUM_W-1:0] q;
        r = {1'b0, div_rem_reg};
        q = num_reg;
        for (int j = 0; j < ter_pkg::DIV_BITS; j++) begin
            r = {r[ter_pkg::REM_W-1:0], q[ter_pkg::NUM_W-1]};
            q = {q[ter_pkg::NUM_W-2:0], 1'b0};
            if (r >= {1'b0, fin}) begin
                r    = r - {1'b0, fin};
                q[0] = 1'b1;
            end
        end
        num_next     = q;
        div_rem_next = r[ter_pkg::REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.mult) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + ter_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            num_reg     <= ter_pkg::NUM_W'(rem_reg) + ter_pkg::NUM_W'(exf);
            div_rem_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg     <= num_next;
            div_rem_reg <= div_rem_next;
        end
    end

    // Window lookups for the current read position
    logic [IDX_W-1:0] i0, i1, fill_x, cons_x;
    logic             use_new0, use_new1;
    logic [AW-1:0]    raddr_a, raddr_b;
    logic [SMP_W-1:0] rdata_a, rdata_b;

    assign i0       = IDX_W'(pos_reg[ter_pkg::POS_W-1:ter_pkg::FRAC_W]);
    assign i1       = i0 + IDX_W'(1);
    assign fill_x   = IDX_W'(fill_reg);
    assign cons_x   = i0;
    assign use_new0 = (i0 >= fill_x);
    assign use_new1 = (i1 >= fill_x);
    assign raddr_a  = use_new0 ? '0 : ring_slot(base_reg, i0[SW-1:0]);
    assign raddr_b  = use_new1 ? '0 : ring_slot(base_reg, i1[SW-1:0]);

    // Window update at the end of an item
    logic              drop_all;
    logic [FILL_W-1:0] fill_left;
    logic              wr_ok;
    logic [AW-1:0]     waddr;

    assign drop_all  = (cons_x > fill_x);
    assign fill_left = fill_reg - FILL_W'(cons_x);
    assign wr_ok     = !drop_all && (fill_left < FILL_W'(WINDOW));
    assign waddr     = ring_slot(base_reg, SW'(fill_reg));

    ter_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WINDOW)
    ) u_history (
        .aclk    (aclk),
        .we      (cmd.commit && wr_ok),
        .waddr   (waddr),
        .wdata   (smp_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Latch the input sample
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            smp_reg <= s_tdata;
        end
    end

    // Multiply the neighbor difference by the fraction
    logic [SMP_W-1:0]        x0, x1;
    logic signed [SMP_W:0]   diff;

    assign x0   = use_new0 ? smp_reg : rdata_a;
    assign x1   = use_new1 ? smp_reg : rdata_b;
    assign diff = $signed({x1[SMP_W-1], x1}) - $signed({x0[SMP_W-1], x0});

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            prod_reg <= diff * $signed({1'b0, pos_reg[ter_pkg::FRAC_W-1:0]});
            x0_reg   <= x0;
        end
    end

    // Add the base sample to the floored product
    logic signed [Y_W-1:0] y;
    assign y = $signed({{(Y_W-SMP_W){x0_reg[SMP_W-1]}}, x0_reg})
             + prod_reg[PROD_W-1:ter_pkg::FRAC_W];

    // Track output count and read position; update remainder and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            pos_reg     <= '0;
            base_reg    <= '0;
            fill_reg    <= '0;
            n_reg       <= '0;
            out_cnt_reg <= '0;
        end else begin
            if (cmd.count) begin
                n_reg       <= (num_reg > ter_pkg::NUM_W'(ter_pkg::MAX_OUT))
                             ? ter_pkg::CNT_W'(ter_pkg::MAX_OUT)
                             : num_reg[ter_pkg::CNT_W-1:0];
                out_cnt_reg <= '0;
                rem_reg     <= div_rem_reg;
            end
            if (cmd.load) begin
                pos_reg     <= pos_reg + ter_pkg::POS_W'(step);
                out_cnt_reg <= out_cnt_reg + ter_pkg::CNT_W'(1);
            end
            if (cmd.commit) begin
                pos_reg <= {{CONS_W{1'b0}}, pos_reg[ter_pkg::FRAC_W-1:0]};
                if (drop_all) begin
                    fill_reg <= '0;
                end else begin
                    base_reg <= ring_slot(base_reg, SW'(cons_x));
                    fill_reg <= wr_ok ? fill_left + FILL_W'(1) : fill_left;
                end
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_sample_reg <= y[SMP_W-1:0];
            out_last_reg   <= sts.last_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    assign sts.div_last = (div_cnt_reg == ter_pkg::DIV_CNT_W'(ter_pkg::DIV_STEPS - 1));
    assign sts.none_due = (num_reg == '0);
    assign sts.last_out = ((out_cnt_reg + ter_pkg::CNT_W'(1)) == n_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

`ifndef SYNTH
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> sts.out_free)
        else $error("result loaded over a held result");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= n_reg)
        else $error("output count ran past the due count");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW))
        else $error("history fill above window depth");
    a_pos_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> pos_reg[ter_pkg::POS_W-1:ter_pkg::FRAC_W] == '0)
        else $error("read position not reduced to a fraction");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count |=> rem_reg < $past(fin))
        else $error("rate remainder not below input rate");
`endif

endmodule

/* hdl/time_expansion_resampler.sv */
// Top level of the time-expansion resampler: controller plus datapath.
//
// Each input item is one signed 16-bit sample. The block works out how many
// outputs are due, expansion*output_rate plus the kept remainder divided by
// input_rate, capped at 64, and produces each by linear interpolation over a
// ring of up to WINDOW history samples held in a two-read-port RAM; m_tlast
// marks the last output of an item. An item passes through these steps in
// order: accept, the rate product, the divider that yields two quotient bits
// per cycle, setting the count, then per output the history read, the
// interpolation multiply and the output register load (which waits while the
// result side stalls), and last the window update. The history needs no
// clearing pass after reset. The user must write configuration through cfg_we,
// cfg_addr (0 input_rate, 1 output_rate, 2 expansion, 3 step) and cfg_data
// only while the block is idle; the block itself does not enforce this.
module time_expansion_resampler #(
    parameter int WINDOW = ter_pkg::WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic [ter_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ter_pkg::CFG_W-1:0]       cfg_data,
    // input samples
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ter_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
    // interpolated samples
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ter_pkg::SAMPLE_W-1:0]    m_tdata,   // [15:0] out_sample
    output logic                            m_tlast    // last_of_run
);

    ter_pkg::ter_cmd_t cmd;
    ter_pkg::ter_sts_t sts;

    ter_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ter_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
